// ----- hdl/sextet_key_decoder_macros.svh -----
// Assertion macros used by the sextet key decoder checker
`ifndef SEXTET_KEY_DECODER_MACROS_SVH
`define SEXTET_KEY_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SKD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKD_ASSERT_NX(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/skd_pkg.sv -----
// Types, constants and lookup functions of the sextet key decoder
package skd_pkg;

  localparam int KEY_SYMBOLS = 12;
  localparam int SEXTET_W    = 6;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 4;
  localparam int KEY_BITS    = KEY_SYMBOLS * SEXTET_W;
  localparam int BURST_LEN   = KEY_BITS / CHAR_W;
  localparam int ALPHA_SIZE  = 64;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(KEY_SYMBOLS);
  localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(BURST_LEN - 1);

  // first symbol sits in the top byte
  localparam logic [ALPHA_SIZE*CHAR_W-1:0] ALPHABET =
    "+-/0123456789:=@ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnpqrstuvwxyz";

  typedef struct packed {
    logic                hit;
    logic [SEXTET_W-1:0] idx;
  } lookup_t;

  // one finished string handed from front to back
  typedef struct packed {
    logic                err;
    logic [KEY_BITS-1:0] bytes;   // byte 0 in the top bits
  } key_entry_t;

  function automatic lookup_t sextet_lookup(input logic [CHAR_W-1:0] c);
    lookup_t r;
    r = '0;
    for (int k = 0; k < ALPHA_SIZE; k++) begin
      if (ALPHABET[CHAR_W*(ALPHA_SIZE-1-k) +: CHAR_W] == c) begin
        r.hit = 1'b1;
        r.idx = SEXTET_W'(k);
      end
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

// ----- hdl/skd_front.sv -----
// Front end: takes characters, classifies them and collects sextets
module skd_front import skd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              q_full,
  output logic              char_ready,
  output logic              push,
  output key_entry_t        push_entry
);

  logic [CNT_W-1:0]    symbol_count;
  logic                error_seen;
  logic [SEXTET_W-1:0] sextet_store [KEY_SYMBOLS];
  logic                take;
  lookup_t             lk;

  assign char_ready = !q_full;
  assign take       = char_valid && char_ready;
  assign lk         = sextet_lookup(char_code);
  assign push       = take && (char_code == CHAR_NUL);

  always_comb begin
    push_entry.err = error_seen || (symbol_count != FULL_COUNT);
    for (int i = 0; i < KEY_SYMBOLS; i++) begin
      push_entry.bytes[KEY_BITS-1-SEXTET_W*i -: SEXTET_W] = sextet_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      error_seen   <= 1'b0;
    end else if (take) begin
      if (char_code == CHAR_NUL) begin
        symbol_count <= '0;
        error_seen   <= 1'b0;
      end else if (!is_blank(char_code) && !error_seen) begin
        if (symbol_count >= FULL_COUNT || !lk.hit) begin
          error_seen <= 1'b1;
        end else begin
          symbol_count <= symbol_count + CNT_W'(1);
        end
      end
    end
  end

  // store is payload: written only for a sextet that counts
  always_ff @(posedge clk) begin
    if (take && char_code != CHAR_NUL && !is_blank(char_code) && !error_seen &&
        symbol_count < FULL_COUNT && lk.hit) begin
      sextet_store[symbol_count] <= lk.idx;
    end
  end

endmodule

// ----- hdl/skd_queue.sv -----
// Two-entry queue of finished strings between front and back
module skd_queue import skd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  key_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output key_entry_t head
);

  key_entry_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule

// ----- hdl/skd_back.sv -----
// Back end: plays one queued string out as a byte burst or an error item
module skd_back import skd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  key_entry_t        q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] data_byte,
  output logic              status,
  output logic              last_byte
);

  logic                busy;
  logic                err;
  logic [KEY_BITS-1:0] shreg;
  logic [CNT_W-1:0]    byte_idx;
  logic                done;

  assign out_valid = busy;
  assign status    = err;
  assign data_byte = err ? '0 : shreg[KEY_BITS-1 -: CHAR_W];
  assign last_byte = err || (byte_idx == LAST_INDEX);
  assign done      = busy && out_ready && last_byte;
  // load a new string when idle or right as the current burst ends
  assign pop       = q_not_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      err      <= q_head.err;
      shreg    <= q_head.bytes;
      byte_idx <= '0;
    end else if (busy && out_ready) begin
      shreg    <= shreg << CHAR_W;
      byte_idx <= byte_idx + CNT_W'(1);
    end
  end

endmodule

// ----- hdl/sextet_key_decoder.sv -----
// Top level of the sextet key decoder: front end, string queue, back end
//
//  channel  dir  tdata           tuser   tlast
//  s_*      in   char_code[7:0]  -       -
//  m_*      out  data_byte[7:0]  status  last_byte
//
// One character per cycle unless the queue is full; a NUL is taken in the same cycle and its result
// burst follows: nine bytes one per cycle while m_tready is high, or one error item.
// The front stalls only when two finished strings wait in the queue.
// A new burst starts in the cycle after the previous one ends if a string already waits in the queue.
// rst is synchronous and active high; it clears counts, flags and the queue.
module sextet_key_decoder import skd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_code
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata,   // [7:0] data_byte
  output logic              m_tuser,   // [0] status
  output logic              m_tlast
);

  logic       q_full;
  logic       q_not_empty;
  logic       push;
  logic       pop;
  key_entry_t push_entry;
  key_entry_t q_head;

  skd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (s_tvalid),
    .char_code  (s_tdata),
    .q_full     (q_full),
    .char_ready (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  skd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  skd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .data_byte   (m_tdata),
    .status      (m_tuser),
    .last_byte   (m_tlast)
  );

endmodule

// ----- hdl/skd_checker.sv -----
// Port-level checks of the sextet key decoder, bound to the top level
`include "sextet_key_decoder_macros.svh"

module skd_checker import skd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [CHAR_W-1:0] m_tdata,
  input logic              m_tuser,
  input logic              m_tlast
);

  // an error result is a single zero item
  `SKD_ASSERT(a_err_item, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "bad error item")

  // a stalled result holds
  `SKD_ASSERT_NX(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

  // a burst runs without gaps up to its last byte
  `SKD_ASSERT_NX(a_burst, m_tvalid && m_tready && !m_tlast, m_tvalid && !m_tuser, "burst broken")

  // bytes ahead of the last one are ok status
  `SKD_ASSERT(a_ok_body, m_tvalid && !m_tlast, !m_tuser, "error inside burst")

endmodule

bind sextet_key_decoder skd_checker u_skd_checker (.*);

// ----- verif/tb_sextet_key_decoder.sv -----
// Self-checking testbench for the sextet key decoder: random key strings, checked bursts
module tb_sextet_key_decoder;
  import skd_pkg::*;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  // symbol k sits at byte 63-k, counted from the low end
  localparam logic [64*8-1:0] KEY_ALPHABET =
    "+-/0123456789:=@ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnpqrstuvwxyz";

  typedef enum int {KEY_GOOD, KEY_EXTRA, KEY_SHORT, KEY_BADCHAR, KEY_NOISE} key_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } key_byte_t;

  class key_byte_tracker;
    logic [SEXTET_W-1:0] sextets [KEY_SYMBOLS];
    int                  taken;
    bit                  flagged;
    key_byte_t           pending_bytes [$];
    int                  mismatches;
    int                  checked;
    int                  decoded;
    int                  rejected;

    static function int sextet_of(input logic [7:0] c);
      for (int k = 0; k < 64; k++) begin
        if (KEY_ALPHABET[8*(63-k) +: 8] == c) return k;
      end
      return -1;
    endfunction

    static function bit blank(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void push(input logic [7:0] d, input logic st, input logic l);
      key_byte_t item;
      item.data   = d;
      item.status = st;
      item.last   = l;
      pending_bytes.push_back(item);
    endfunction

    function void take_char(input logic [7:0] c);
      int                  v;
      logic [SEXTET_W-1:0] s0, s1, s2, s3;
      if (c == CHAR_NUL) begin
        if (flagged || taken != KEY_SYMBOLS) begin
          push(8'h00, ST_BAD, 1'b1);
          rejected++;
        end else begin
          for (int g = 0; g < 3; g++) begin
            s0 = sextets[4*g];
            s1 = sextets[4*g+1];
            s2 = sextets[4*g+2];
            s3 = sextets[4*g+3];
            push({s0, s1[5:4]}, ST_OK, 1'b0);
            push({s1[3:0], s2[5:2]}, ST_OK, 1'b0);
            push({s2[1:0], s3}, ST_OK, g == 2);
          end
          decoded++;
        end
        taken   = 0;
        flagged = 0;
      end else if (!blank(c) && !flagged) begin
        // a thirteenth symbol poisons the string just like a bad character
        if (taken >= KEY_SYMBOLS) begin
          flagged = 1;
        end else begin
          v = sextet_of(c);
          if (v < 0) begin
            flagged = 1;
          end else begin
            sextets[taken] = v[SEXTET_W-1:0];
            taken++;
          end
        end
      end
    endfunction

    function void match_byte(input logic [7:0] d, input logic st, input logic l);
      key_byte_t want;
      checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transfer data=%h status=%b last=%b", $time, d, st, l);
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== d || want.status !== st || want.last !== l) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp data=%h status=%b last=%b, got data=%h status=%b last=%b",
                     $time, want.data, want.status, want.last, d, st, l);
        end
      end
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [CHAR_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  key_byte_tracker tracker;
  bit              calm;
  int              items_sent;
  int              strings_sent;

  sextet_key_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CHAR_SPACE : 8'(9 + r);
  endfunction

  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (key_byte_tracker::sextet_of(c) >= 0 || key_byte_tracker::blank(c));
    return c;
  endfunction

  function automatic logic [7:0] symbol_char();
    return KEY_ALPHABET[8*(63 - $urandom_range(0, 63)) +: 8];
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_char(c);
    items_sent++;
  endtask

  task automatic send_string(input key_kind_t kind);
    logic [7:0] text [$];
    int         keep;
    for (int i = 0; i < KEY_SYMBOLS; i++) text.push_back(symbol_char());
    case (kind)
      KEY_EXTRA: begin
        repeat ($urandom_range(1, 2)) text.push_back(symbol_char());
      end
      KEY_SHORT: begin
        keep = $urandom_range(0, KEY_SYMBOLS - 1);
        while (text.size() > keep) void'(text.pop_back());
      end
      KEY_BADCHAR: begin
        text[$urandom_range(0, KEY_SYMBOLS - 1)] = odd_char();
      end
      KEY_NOISE: begin
        text.delete();
        repeat ($urandom_range(1, 16)) text.push_back(8'($urandom_range(1, 255)));
      end
      default: ;
    endcase
    foreach (text[i]) begin
      if ($urandom_range(0, 6) == 0) send_char(blank_char());
      send_char(text[i]);
    end
    if ($urandom_range(0, 4) == 0) send_char(blank_char());
    send_char(CHAR_NUL);
    strings_sent++;
  endtask

  // result side: check every transfer, stall m_tready at random
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.match_byte(m_tdata, m_tuser, m_tlast);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    logic [7:0] directed [$];
    int         r;
    bit         drained;
    tracker = new();
    // all-zero and all-one sextets, every blank code, a bare NUL,
    // then a bad character followed by a symbol that must be ignored
    directed = '{"+", "+", "+", "+", 8'h20, "z", "z", "z", "z", 8'h09, "+", "z", 8'h0a,
                 "-", "y", 8'h0b, "9", 8'h0c, "A", 8'h0d, CHAR_NUL,
                 CHAR_NUL,
                 8'hff, "A", CHAR_NUL};
    drained = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_char(directed[i]);
    strings_sent = 3;
    while (items_sent < 220) begin
      calm = (strings_sent % 6 == 3);
      if (!drained && items_sent >= 110) begin
        // hold off input until every pending burst has gone out
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0) @(posedge clk);
        drained = 1;
      end
      r = $urandom_range(0, 99);
      if (r < 55)      send_string(KEY_GOOD);
      else if (r < 67) send_string(KEY_EXTRA);
      else if (r < 79) send_string(KEY_SHORT);
      else if (r < 91) send_string(KEY_BADCHAR);
      else             send_string(KEY_NOISE);
    end
    calm = 0;
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("sent %0d key strings: %0d decoded to nine bytes, %0d rejected",
             strings_sent, tracker.decoded, tracker.rejected);
    $display("checked %0d output transfers, %0d mismatches", tracker.checked,
             tracker.mismatches);
    if (tracker.outstanding() != 0)
      $display("%0d expected outputs never arrived", tracker.outstanding());
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb_sextet_key_decoder: clean");
    end else begin
      $display("tb_sextet_key_decoder: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("run timed out");
    $display("tb_sextet_key_decoder: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/skd_pkg.sv
hdl/skd_front.sv
hdl/skd_queue.sv
hdl/skd_back.sv
hdl/sextet_key_decoder.sv
hdl/skd_checker.sv
verif/tb_sextet_key_decoder.sv
